// File: rtl/wft_pkg.sv
// Shared constants, codes and types of the word frequency table.
// No dependencies; every other file imports this package.
package wft_pkg;

   localparam int TABLE_DEPTH = 256;
   localparam int WORD_LEN    = 16;
   localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int USED_W      = $clog2(TABLE_DEPTH + 1);
   localparam int LEN_W       = $clog2(WORD_LEN + 1);
   localparam int POS_W       = (WORD_LEN > 1) ? $clog2(WORD_LEN) : 1;
   localparam int ROW_W       = WORD_LEN * 8;
   localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

   typedef enum logic [1:0] {
      OP_BYTE = 2'd0,
      OP_END  = 2'd1,
      OP_READ = 2'd2,
      OP_NOP  = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_COUNTED   = 3'd0,
      ST_ADDED     = 3'd1,
      ST_FULL      = 3'd2,
      ST_CHAR      = 3'd3,
      ST_BAD_INDEX = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SCAN_RD,
      S_SCAN_CMP,
      S_UPDATE,
      S_APPEND,
      S_FULL,
      S_BAD,
      S_READ_RD,
      S_READ_LOAD,
      S_READ_OUT
   } state_type;

   // Broadcast control for the row of character cells.
   typedef struct packed {
      logic             write_en;
      logic [POS_W-1:0] write_pos;
      logic [7:0]       write_byte;
      logic             load_row;
      logic             shift;
   } cell_ctrl_type;

   // Write port control of the entry table.
   typedef struct packed {
      logic             write_entry;
      logic             write_count;
      logic [IDX_W-1:0] addr;
      logic [LEN_W-1:0] len;
      logic [31:0]      count;
   } table_wr_type;

   function automatic logic is_space(input logic [7:0] b);
      return (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));
   endfunction

endpackage

// File: rtl/wft_if.sv
// Valid/ready channel interfaces for request and response beats.
// Depends on wft_pkg.
interface wft_req_if import wft_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [1:0] operation;
   logic [7:0] text_byte;
   logic [7:0] read_index;

   modport source (output valid, output operation, output text_byte, output read_index,
                   input ready);
   modport sink   (input valid, input operation, input text_byte, input read_index,
                   output ready);
endinterface

interface wft_rsp_if import wft_pkg::*; ();
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [7:0]  entry_index;
   logic [31:0] word_count;
   logic [7:0]  char_out;
   logic        truncated;
   logic        last;

   modport source (output valid, output status, output entry_index, output word_count,
                   output char_out, output truncated, output last, input ready);
   modport sink   (input valid, input status, input entry_index, input word_count,
                   input char_out, input truncated, input last, output ready);
endinterface

// File: rtl/word_frequency_table_top.sv
// Word frequency table top level: controller, row of character cells, entry store.
// Depends on wft_pkg, wft_if, wft_cell and wft_table.
//
// Text bytes are taken one per cycle while no word lookup or readout is in
// progress. Closing a word scans the stored entries in insertion order
// through the single read port of the entry store, reading each entry and
// then comparing it across all character cells at once, and waits for the
// response slot before reporting. A readout reads the entry, loads its row
// into the cells and then sends its characters as beats. No new request is
// taken until the current lookup or readout has handed its last beat to the
// response register.
module word_frequency_table_top import wft_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   wft_req_if.sink req_bus,
   wft_rsp_if.source rsp_bus
);

   state_type        state_ff, state_in;
   logic [LEN_W-1:0] pend_len_ff, pend_len_in;
   logic             pend_ovf_ff, pend_ovf_in;
   logic [USED_W-1:0] used_ff, used_in;
   logic [IDX_W-1:0] scan_ff, scan_in;
   logic             trunc_ff, trunc_in;
   logic [7:0]       rd_idx_ff, rd_idx_in;
   logic [LEN_W-1:0] rd_len_ff, rd_len_in;
   logic [31:0]      rd_count_ff, rd_count_in;
   logic [LEN_W-1:0] rd_pos_ff, rd_pos_in;
   logic [31:0]      cnt_ff, cnt_in;

   logic        rsp_valid_ff, rsp_valid_in;
   status_type  status_ff, status_in;
   logic [7:0]  index_ff, index_in;
   logic [31:0] count_ff, count_in;
   logic [7:0]  char_ff, char_in;
   logic        trunc_out_ff, trunc_out_in;
   logic        last_ff, last_in;

   logic req_fire, out_free, close_req, bad_index, row_match, read_last;
   op_type op;

   cell_ctrl_type    cell_ctrl;
   table_wr_type     tbl_wr;
   logic [IDX_W-1:0] tbl_rd_addr;
   logic [ROW_W-1:0] rd_chars, wr_chars;
   logic [LEN_W-1:0] rd_len;
   logic [31:0]      rd_count;
   logic [7:0]       chain [WORD_LEN+1];
   logic [WORD_LEN-1:0] lane_match;

   assign op        = op_type'(req_bus.operation);
   assign req_fire  = req_bus.valid && req_bus.ready;
   assign out_free  = !rsp_valid_ff || rsp_bus.ready;
   assign close_req = (((op == OP_BYTE) && is_space(req_bus.text_byte)) || (op == OP_END))
                      && (pend_len_ff != '0);
   assign bad_index = {{(USED_W > 8 ? USED_W - 8 : 0){1'b0}}, req_bus.read_index}
                      >= used_ff;
   assign row_match = (&lane_match) && (rd_len == pend_len_ff);
   assign read_last = ((rd_pos_ff + LEN_W'(1)) == rd_len_ff);

   // Row of character cells; readout data moves toward cell zero.
   assign chain[WORD_LEN] = 8'h00;
   for (genvar k = 0; k < WORD_LEN; k++) begin : g_cell
      wft_cell u_cell (
         .clock      (clock),
         .ctrl       (cell_ctrl),
         .cell_pos   (POS_W'(k)),
         .pend_len   (pend_len_ff),
         .row_char   (rd_chars[k*8 +: 8]),
         .shift_in   (chain[k+1]),
         .pend_char  (wr_chars[k*8 +: 8]),
         .shift_out  (chain[k]),
         .lane_match (lane_match[k])
      );
   end

   wft_table u_table (
      .clock    (clock),
      .rd_addr  (tbl_rd_addr),
      .wr       (tbl_wr),
      .wr_chars (wr_chars),
      .rd_chars (rd_chars),
      .rd_len   (rd_len),
      .rd_count (rd_count)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (close_req) begin
                  state_in = (used_ff == '0) ? S_APPEND : S_SCAN_RD;
               end else if (op == OP_READ) begin
                  state_in = bad_index ? S_BAD : S_READ_RD;
               end
            end
         end
         S_SCAN_RD:  state_in = S_SCAN_CMP;
         S_SCAN_CMP: begin
            if (row_match) begin
               state_in = S_UPDATE;
            end else if ((USED_W'(scan_ff) + USED_W'(1)) < used_ff) begin
               state_in = S_SCAN_RD;
            end else if (used_ff < USED_W'(TABLE_DEPTH)) begin
               state_in = S_APPEND;
            end else begin
               state_in = S_FULL;
            end
         end
         S_UPDATE, S_APPEND, S_FULL, S_BAD: begin
            if (out_free) state_in = S_IDLE;
         end
         S_READ_RD:   state_in = S_READ_LOAD;
         S_READ_LOAD: state_in = S_READ_OUT;
         S_READ_OUT: begin
            if (out_free && read_last) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Datapath, cell control, table access and response register.
   always_comb begin
      pend_len_in  = pend_len_ff;
      pend_ovf_in  = pend_ovf_ff;
      used_in      = used_ff;
      scan_in      = scan_ff;
      trunc_in     = trunc_ff;
      rd_idx_in    = rd_idx_ff;
      rd_len_in    = rd_len_ff;
      rd_count_in  = rd_count_ff;
      rd_pos_in    = rd_pos_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      status_in    = status_ff;
      index_in     = index_ff;
      count_in     = count_ff;
      char_in      = char_ff;
      trunc_out_in = trunc_out_ff;
      last_in      = last_ff;

      cell_ctrl            = '0;
      cell_ctrl.write_pos  = pend_len_ff[POS_W-1:0];
      cell_ctrl.write_byte = req_bus.text_byte;
      tbl_wr               = '0;
      tbl_wr.addr          = scan_ff;
      tbl_wr.len           = pend_len_ff;
      tbl_rd_addr          = (state_ff == S_READ_RD) ? rd_idx_ff[IDX_W-1:0] : scan_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (close_req) begin
                  trunc_in = pend_ovf_ff;
                  scan_in  = '0;
               end else if ((op == OP_BYTE) && !is_space(req_bus.text_byte)) begin
                  if (pend_len_ff < LEN_W'(WORD_LEN)) begin
                     cell_ctrl.write_en = 1'b1;
                     pend_len_in        = pend_len_ff + LEN_W'(1);
                  end else begin
                     pend_ovf_in = 1'b1;
                  end
               end else if (op == OP_READ) begin
                  rd_idx_in = req_bus.read_index;
               end
            end
         end
         S_SCAN_CMP: begin
            cnt_in = rd_count;
            if (!row_match) begin
               scan_in = scan_ff + IDX_W'(1);
            end
         end
         S_UPDATE: begin
            if (out_free) begin
               tbl_wr.write_count = 1'b1;
               tbl_wr.count       = (cnt_ff == COUNT_MAX) ? cnt_ff : cnt_ff + 32'd1;
               rsp_valid_in = 1'b1;
               status_in    = ST_COUNTED;
               index_in     = 8'(scan_ff);
               count_in     = tbl_wr.count;
               char_in      = 8'h00;
               trunc_out_in = trunc_ff;
               last_in      = 1'b1;
               pend_len_in  = '0;
               pend_ovf_in  = 1'b0;
            end
         end
         S_APPEND: begin
            tbl_wr.addr = used_ff[IDX_W-1:0];
            if (out_free) begin
               tbl_wr.write_entry = 1'b1;
               tbl_wr.count       = 32'd1;
               used_in      = used_ff + USED_W'(1);
               rsp_valid_in = 1'b1;
               status_in    = ST_ADDED;
               index_in     = 8'(used_ff);
               count_in     = 32'd1;
               char_in      = 8'h00;
               trunc_out_in = trunc_ff;
               last_in      = 1'b1;
               pend_len_in  = '0;
               pend_ovf_in  = 1'b0;
            end
         end
         S_FULL: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               status_in    = ST_FULL;
               index_in     = 8'h00;
               count_in     = 32'd0;
               char_in      = 8'h00;
               trunc_out_in = trunc_ff;
               last_in      = 1'b1;
               pend_len_in  = '0;
               pend_ovf_in  = 1'b0;
            end
         end
         S_BAD: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               status_in    = ST_BAD_INDEX;
               index_in     = rd_idx_ff;
               count_in     = 32'd0;
               char_in      = 8'h00;
               trunc_out_in = 1'b0;
               last_in      = 1'b1;
            end
         end
         S_READ_LOAD: begin
            cell_ctrl.load_row = 1'b1;
            rd_len_in   = rd_len;
            rd_count_in = rd_count;
            rd_pos_in   = '0;
         end
         S_READ_OUT: begin
            if (out_free) begin
               cell_ctrl.shift = 1'b1;
               rd_pos_in    = rd_pos_ff + LEN_W'(1);
               rsp_valid_in = 1'b1;
               status_in    = ST_CHAR;
               index_in     = rd_idx_ff;
               count_in     = rd_count_ff;
               char_in      = chain[0];
               trunc_out_in = 1'b0;
               last_in      = read_last;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pend_len_ff  <= '0;
         pend_ovf_ff  <= 1'b0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_len_ff  <= pend_len_in;
         pend_ovf_ff  <= pend_ovf_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff      <= scan_in;
      trunc_ff     <= trunc_in;
      rd_idx_ff    <= rd_idx_in;
      rd_len_ff    <= rd_len_in;
      rd_count_ff  <= rd_count_in;
      rd_pos_ff    <= rd_pos_in;
      cnt_ff       <= cnt_in;
      status_ff    <= status_in;
      index_ff     <= index_in;
      count_ff     <= count_in;
      char_ff      <= char_in;
      trunc_out_ff <= trunc_out_in;
      last_ff      <= last_in;
   end

   assign req_bus.ready       = (state_ff == S_IDLE);
   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.status      = status_ff;
   assign rsp_bus.entry_index = index_ff;
   assign rsp_bus.word_count  = count_ff;
   assign rsp_bus.char_out    = char_ff;
   assign rsp_bus.truncated   = trunc_out_ff;
   assign rsp_bus.last        = last_ff;

   // The pending word never grows past the cell row.
   a_pend_len: assert property (@(posedge clock) disable iff (reset)
      pend_len_ff <= LEN_W'(WORD_LEN))
      else $error("pending length beyond cell row");

   // The fill count never passes the table depth.
   a_used: assert property (@(posedge clock) disable iff (reset)
      used_ff <= USED_W'(TABLE_DEPTH))
      else $error("entry fill count beyond table depth");

   // Appending a word grows the table by exactly one entry.
   a_append: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_APPEND && out_free) |=> (used_ff == $past(used_ff) + USED_W'(1)))
      else $error("append did not grow the table");

   // A dropped word is only reported when the table is full.
   a_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && status_ff == ST_FULL) |-> (used_ff == USED_W'(TABLE_DEPTH)))
      else $error("drop reported with room in the table");

   // A closed word leaves no pending characters behind.
   a_cleared: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_UPDATE || state_ff == S_APPEND || state_ff == S_FULL) && out_free)
      |=> (pend_len_ff == '0))
      else $error("pending word not cleared after close");

endmodule

// File: rtl/wft_cell.sv
// One character cell: holds a pending word character, compares it with the
// matching lane of a stored row, and passes readout characters to its neighbor.
// Depends on wft_pkg.
module wft_cell import wft_pkg::*; (
   input  logic             clock,
   input  cell_ctrl_type    ctrl,
   input  logic [POS_W-1:0] cell_pos,
   input  logic [LEN_W-1:0] pend_len,
   input  logic [7:0]       row_char,
   input  logic [7:0]       shift_in,
   output logic [7:0]       pend_char,
   output logic [7:0]       shift_out,
   output logic             lane_match
);

   logic [7:0] pend_ff, pend_in;
   logic [7:0] rd_ff, rd_in;

   // Capture a text byte when the write position reaches this cell.
   always_comb begin
      pend_in = pend_ff;
      if (ctrl.write_en && (ctrl.write_pos == cell_pos)) begin
         pend_in = ctrl.write_byte;
      end
   end

   // Readout register loads a whole row, then shifts toward cell zero.
   always_comb begin
      rd_in = rd_ff;
      if (ctrl.load_row) begin
         rd_in = row_char;
      end else if (ctrl.shift) begin
         rd_in = shift_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
      rd_ff   <= rd_in;
   end

   // Lanes past the pending length do not take part in the compare.
   assign lane_match = (LEN_W'(cell_pos) >= pend_len) || (pend_ff == row_char);
   assign pend_char  = pend_ff;
   assign shift_out  = rd_ff;

endmodule

// File: rtl/wft_table.sv
// Entry store: characters, length and count of every table entry, with one
// registered read port and one write port. Depends on wft_pkg.
module wft_table import wft_pkg::*; (
   input  logic             clock,
   input  logic [IDX_W-1:0] rd_addr,
   input  table_wr_type     wr,
   input  logic [ROW_W-1:0] wr_chars,
   output logic [ROW_W-1:0] rd_chars,
   output logic [LEN_W-1:0] rd_len,
   output logic [31:0]      rd_count
);

   logic [ROW_W-1:0] chars_mem [TABLE_DEPTH];
   logic [LEN_W-1:0] len_mem   [TABLE_DEPTH];
   logic [31:0]      count_mem [TABLE_DEPTH];

   // A new entry writes every field; a repeated word writes only its count.
   always_ff @(posedge clock) begin
      if (wr.write_entry) begin
         chars_mem[wr.addr] <= wr_chars;
         len_mem[wr.addr]   <= wr.len;
      end
      if (wr.write_entry || wr.write_count) begin
         count_mem[wr.addr] <= wr.count;
      end
   end

   always_ff @(posedge clock) begin
      rd_chars <= chars_mem[rd_addr];
      rd_len   <= len_mem[rd_addr];
      rd_count <= count_mem[rd_addr];
   end

endmodule
